// ===== hw/rtl/typed_id_allocator_assert.svh =====
// Assertion macros for the checker of the typed identifier allocator.
// No dependencies; include by bare file name.
`ifndef TYPED_ID_ALLOCATOR_ASSERT_SVH
`define TYPED_ID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tia_pkg.sv =====
// Package of the typed identifier allocator: beat types, codes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package tia_pkg;

  localparam int unsigned NumTypesDef  = 8;
  localparam int unsigned FreeDepthDef = 64;
  localparam int unsigned IdWidthDef   = 32;

  localparam int unsigned TypeIdxW = 3;
  localparam int unsigned RelIdW   = 32;
  localparam int unsigned GivenIdW = 32;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } tia_cmd_e;

  typedef enum logic [2:0] {
    ST_FRESH     = 3'd0,
    ST_REUSED    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_BEYOND    = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_FULL      = 3'd5
  } tia_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_STORE
  } tia_state_e;

  typedef struct packed {
    tia_cmd_e              command;
    logic [TypeIdxW-1:0]   type_index;
    logic [RelIdW-1:0]     release_id;
  } tia_in_t;

  typedef struct packed {
    logic [GivenIdW-1:0]   given_id;
    tia_status_e           status;
  } tia_out_t;

  // Memory actions requested by the decision logic for one beat.
  typedef struct packed {
    logic meta_we;
    logic store_we;
    logic store_re;
  } tia_ctl_t;

endpackage

// ===== hw/rtl/tia_decide.sv =====
// Decision logic of the typed identifier allocator: per-type metadata update and result.
// Depends on tia_pkg.
`timescale 1ns / 1ps

module tia_decide import tia_pkg::*; #(
  parameter int unsigned NUM_TYPES  = NumTypesDef,
  parameter int unsigned FREE_DEPTH = FreeDepthDef,
  parameter int unsigned ID_WIDTH   = IdWidthDef,
  localparam int unsigned TW     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1,
  localparam int unsigned HEAD_W = $clog2(FREE_DEPTH),
  localparam int unsigned FILL_W = $clog2(FREE_DEPTH + 1),
  localparam int unsigned META_W = ID_WIDTH + HEAD_W + FILL_W,
  localparam int unsigned SA_W   = $clog2(NUM_TYPES * FREE_DEPTH),
  localparam int unsigned SW     = (ID_WIDTH < 32) ? ID_WIDTH : 32,
  localparam int unsigned CMP_W  = (ID_WIDTH > 32) ? ID_WIDTH : 32
) (
  input  tia_cmd_e              command_i,
  input  logic [TW-1:0]         type_i,
  input  logic [RelIdW-1:0]     release_id_i,
  input  logic [META_W-1:0]     meta_i,
  output logic [META_W-1:0]     meta_o,
  output logic [SA_W-1:0]       store_addr_o,
  output tia_ctl_t              ctl_o,
  output tia_status_e           status_o,
  output logic [GivenIdW-1:0]   given_id_o
);

  logic [ID_WIDTH-1:0] cnt, cnt_inc, cnt_d;
  logic [HEAD_W-1:0]   head, head_inc, head_d, tail, offset;
  logic [FILL_W-1:0]   fill, fill_d;
  logic [HEAD_W:0]     tail_sum;
  logic [CMP_W-1:0]    rid_ext, cnt_ext, inc_ext;
  logic [SA_W-1:0]     base;

  assign {cnt, head, fill} = meta_i;
  assign cnt_inc  = cnt + 1'b1;
  assign head_inc = (head == HEAD_W'(FREE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = {1'b0, head} + {1'b0, fill[HEAD_W-1:0]};
  assign tail     = (tail_sum >= (HEAD_W + 1)'(FREE_DEPTH)) ?
                    HEAD_W'(tail_sum - (HEAD_W + 1)'(FREE_DEPTH)) : tail_sum[HEAD_W-1:0];
  assign rid_ext  = CMP_W'(release_id_i[SW-1:0]);
  assign cnt_ext  = CMP_W'(cnt);
  assign inc_ext  = CMP_W'(cnt_inc);
  assign base     = SA_W'(type_i * FREE_DEPTH);

  always_comb begin
    cnt_d      = cnt;
    head_d     = head;
    fill_d     = fill;
    offset     = head;
    ctl_o      = '0;
    given_id_o = '0;
    status_o   = ST_FRESH;
    case (command_i)
      CMD_ALLOC: begin
        if (fill != '0) begin
          ctl_o.store_re = 1'b1;
          ctl_o.meta_we  = 1'b1;
          head_d         = head_inc;
          fill_d         = fill - 1'b1;
          status_o       = ST_REUSED;
        end else if (&cnt) begin
          status_o = ST_EXHAUSTED;
        end else begin
          ctl_o.meta_we = 1'b1;
          cnt_d         = cnt_inc;
          given_id_o    = inc_ext[GivenIdW-1:0];
          status_o      = ST_FRESH;
        end
      end
      CMD_RELEASE: begin
        if (rid_ext > cnt_ext) begin
          status_o = ST_BEYOND;
        end else if (fill >= FILL_W'(FREE_DEPTH)) begin
          status_o = ST_FULL;
        end else begin
          ctl_o.store_we = 1'b1;
          ctl_o.meta_we  = 1'b1;
          fill_d         = fill + 1'b1;
          offset         = tail;
          status_o       = ST_RELEASED;
        end
      end
      default: begin
        status_o = ST_FRESH;
      end
    endcase
  end

  assign meta_o       = {cnt_d, head_d, fill_d};
  assign store_addr_o = base + SA_W'(offset);

endmodule

// ===== hw/rtl/typed_id_allocator.sv =====
// A beat accepted in the idle state has its per-type metadata read into a register; the
// result is decided from it and registered at the output, after a registered free-list read
// when the identifier comes from the free list. A new beat is accepted only once the last
// result is loaded. Reset: counters and free lists come up empty at once through per-type
// valid bits; the free-list store itself is not cleared and needs no clearing pass.
// Top level of the typed identifier allocator; depends on tia_pkg and tia_decide.
`timescale 1ns / 1ps

module typed_id_allocator import tia_pkg::*; #(
  parameter int unsigned NUM_TYPES  = NumTypesDef,
  parameter int unsigned FREE_DEPTH = FreeDepthDef,
  parameter int unsigned ID_WIDTH   = IdWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tia_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tia_out_t out_data_o
);

  localparam int unsigned TW     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned HEAD_W = $clog2(FREE_DEPTH);
  localparam int unsigned FILL_W = $clog2(FREE_DEPTH + 1);
  localparam int unsigned META_W = ID_WIDTH + HEAD_W + FILL_W;
  localparam int unsigned SA_W   = $clog2(NUM_TYPES * FREE_DEPTH);
  localparam int unsigned SW     = (ID_WIDTH < 32) ? ID_WIDTH : 32;

  // Per-type metadata memory holds {counter, free-list head, free-list fill}.
  // An entry whose valid bit is clear reads as all zeros, which is its reset state.
  logic [META_W-1:0] meta_mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] meta_vld_q;
  logic [META_W-1:0] meta_rd_q;
  logic              meta_rd_vld_q;
  logic [META_W-1:0] meta_cur, meta_nxt;
  logic              meta_re;

  // Free-list store: one ring of FREE_DEPTH entries per type, laid out type after type.
  logic [SW-1:0]     store_mem [NUM_TYPES * FREE_DEPTH];
  logic [SW-1:0]     store_rd_q;
  logic [SA_W-1:0]   store_addr;

  tia_state_e state_q, state_d;
  tia_in_t    item_q;
  logic [TW-1:0] type_red, type_q;
  logic [6:0] type_mod;

  tia_ctl_t    ctl;
  tia_status_e dec_status;
  logic [GivenIdW-1:0] dec_given;

  logic     out_free, out_load, do_meta_we, do_store_we, do_store_re;
  tia_out_t out_d;
  logic     out_valid_q;
  tia_out_t out_data_q;

  // A type index at or above NUM_TYPES folds back by repeated subtraction; the input
  // is only three bits wide, so a handful of narrow steps cover every value.
  always_comb begin
    type_mod = 7'(in_data_i.type_index);
    for (int i = 0; i < 8; i++) begin
      if (type_mod >= 7'(NUM_TYPES)) begin
        type_mod = type_mod - 7'(NUM_TYPES);
      end
    end
    type_red = type_mod[TW-1:0];
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: accept, then resolve the metadata, then read the free list if reused.
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    meta_re     = 1'b0;
    do_meta_we  = 1'b0;
    do_store_we = 1'b0;
    do_store_re = 1'b0;
    out_load    = 1'b0;
    out_d.given_id = dec_given;
    out_d.status   = dec_status;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          meta_re = 1'b1;
          state_d = S_META;
        end
      end
      S_META: begin
        if (ctl.store_re) begin
          // Reuse: commit the pop now and fetch the oldest free identifier.
          do_meta_we  = 1'b1;
          do_store_re = 1'b1;
          state_d     = S_STORE;
        end else if (out_free) begin
          do_meta_we  = ctl.meta_we;
          do_store_we = ctl.store_we;
          out_load    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_STORE: begin
        out_d.given_id = GivenIdW'(store_rd_q);
        out_d.status   = ST_REUSED;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      meta_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_meta_we) begin
        meta_vld_q[type_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: the accepted beat, the read ports and the output beat.
  always_ff @(posedge clk_i) begin
    if (meta_re) begin
      item_q        <= in_data_i;
      type_q        <= type_red;
      meta_rd_q     <= meta_mem[type_red];
      meta_rd_vld_q <= meta_vld_q[type_red];
    end
    if (out_load) begin
      out_data_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_meta_we) begin
      meta_mem[type_q] <= meta_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store_we) begin
      store_mem[store_addr] <= item_q.release_id[SW-1:0];
    end
    if (do_store_re) begin
      store_rd_q <= store_mem[store_addr];
    end
  end

  assign meta_cur = meta_rd_vld_q ? meta_rd_q : '0;

  tia_decide #(
    .NUM_TYPES  (NUM_TYPES),
    .FREE_DEPTH (FREE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_decide (
    .command_i    (item_q.command),
    .type_i       (type_q),
    .release_id_i (item_q.release_id),
    .meta_i       (meta_cur),
    .meta_o       (meta_nxt),
    .store_addr_o (store_addr),
    .ctl_o        (ctl),
    .status_o     (dec_status),
    .given_id_o   (dec_given)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/tia_checker.sv =====
// Port-level checker of the typed identifier allocator, bound to the top level.
// Depends on tia_pkg and typed_id_allocator_assert.svh.
`timescale 1ns / 1ps
`include "typed_id_allocator_assert.svh"

module tia_checker import tia_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input tia_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tia_out_t out_data_o
);

  logic in_seen;
  assign in_seen = in_valid_i && (in_data_i.command == CMD_ALLOC || in_ready_o);

  // A stalled result beat stays put.
  `TIA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output beat changed while stalled")

  // One request at a time: the cycle after an accept the input side is closed.
  `TIA_ASSERT_NXT(a_one_inflight, clk_i, rst_ni, in_seen && in_ready_o, !in_ready_o, "input accepted again in the cycle after an accept")

  // Only allocations that hand out an identifier may carry a nonzero one.
  `TIA_ASSERT_IMP(a_zero_given, clk_i, rst_ni, out_valid_o && (out_data_o.status == ST_RELEASED || out_data_o.status == ST_BEYOND || out_data_o.status == ST_EXHAUSTED || out_data_o.status == ST_FULL), out_data_o.given_id == '0, "nonzero identifier on a result that gives none")

endmodule

bind typed_id_allocator tia_checker u_tia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
